// ----- src/dmwtc_pkg.sv -----
// Shared types and constants for the direct-mapped write-through cache core.
`default_nettype none
package dmwtc_pkg;

    localparam int ADDR_W     = 10;
    localparam int WORD_W     = 32;
    localparam int RECIP_W    = 12;
    localparam int DIV_CNT_W  = 4;
    localparam int SHIFT_W    = 5;
    localparam int LINE_OUT_W = 4;
    localparam int OFF_OUT_W  = 2;
    localparam int TAG_OUT_W  = 4;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV_MOD,
        ST_DIV_TAG,
        ST_DIV_LRAW,
        ST_DIV_LINE,
        ST_DIV_OFF,
        ST_TAG_RD,
        ST_CHECK,
        ST_MEM_WR,
        ST_FILL,
        ST_HIT_RD,
        ST_DONE
    } st_t;

    typedef enum logic [1:0] {
        DIV_MEM,
        DIV_CACHE,
        DIV_BLOCK,
        DIV_LINES
    } div_op_t;

    typedef struct packed {
        logic              start;
        div_op_t           op;
        logic [ADDR_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quot;
        logic [ADDR_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
    } tag_ent_t;

endpackage
`default_nettype wire

// ----- src/dmwtc_div.sv -----
// Shared divide-by-constant unit: shift and mask for powers of two, else reciprocal multiply.
`default_nettype none
module dmwtc_div #(
    parameter int MEM_WORDS   = 1024,
    parameter int CACHE_WORDS = 64,
    parameter int BLOCK_WORDS = 4,
    parameter int NUM_LINES   = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  dmwtc_pkg::div_req_t req,
    output dmwtc_pkg::div_rsp_t rsp
);

    localparam int AW = dmwtc_pkg::ADDR_W;
    localparam int SW = dmwtc_pkg::SHIFT_W;
    localparam int CW = dmwtc_pkg::DIV_CNT_W;
    localparam int RW = dmwtc_pkg::RECIP_W;
    localparam int PW = AW + RW;

    localparam logic [63:0] ONE = 64'd1;

    // keep low bits only: quotient times divisor never exceeds the dividend
    localparam logic [AW-1:0] DV_MEM   = AW'(MEM_WORDS);
    localparam logic [AW-1:0] DV_CACHE = AW'(CACHE_WORDS);
    localparam logic [AW-1:0] DV_BLOCK = AW'(BLOCK_WORDS);
    localparam logic [AW-1:0] DV_LINES = AW'(NUM_LINES);

    localparam bit P2_MEM   = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam bit P2_CACHE = (CACHE_WORDS & (CACHE_WORDS - 1)) == 0;
    localparam bit P2_BLOCK = (BLOCK_WORDS & (BLOCK_WORDS - 1)) == 0;
    localparam bit P2_LINES = (NUM_LINES & (NUM_LINES - 1)) == 0;

    localparam logic [SW-1:0] SH_MEM   = SW'($clog2(MEM_WORDS));
    localparam logic [SW-1:0] SH_CACHE = SW'($clog2(CACHE_WORDS));
    localparam logic [SW-1:0] SH_BLOCK = SW'($clog2(BLOCK_WORDS));
    localparam logic [SW-1:0] SH_LINES = SW'($clog2(NUM_LINES));

    localparam logic [AW-1:0] MK_MEM   = AW'(MEM_WORDS - 1);
    localparam logic [AW-1:0] MK_CACHE = AW'(CACHE_WORDS - 1);
    localparam logic [AW-1:0] MK_BLOCK = AW'(BLOCK_WORDS - 1);
    localparam logic [AW-1:0] MK_LINES = AW'(NUM_LINES - 1);

    localparam int RS_MEM_I   = AW + $clog2(MEM_WORDS);
    localparam int RS_CACHE_I = AW + $clog2(CACHE_WORDS);
    localparam int RS_BLOCK_I = AW + $clog2(BLOCK_WORDS);
    localparam int RS_LINES_I = AW + $clog2(NUM_LINES);

    localparam logic [SW-1:0] RS_MEM   = SW'(RS_MEM_I);
    localparam logic [SW-1:0] RS_CACHE = SW'(RS_CACHE_I);
    localparam logic [SW-1:0] RS_BLOCK = SW'(RS_BLOCK_I);
    localparam logic [SW-1:0] RS_LINES = SW'(RS_LINES_I);

    localparam logic [RW-1:0] RC_MEM   =
        RW'(((ONE << RS_MEM_I) + 64'(MEM_WORDS) - ONE) / 64'(MEM_WORDS));
    localparam logic [RW-1:0] RC_CACHE =
        RW'(((ONE << RS_CACHE_I) + 64'(CACHE_WORDS) - ONE) / 64'(CACHE_WORDS));
    localparam logic [RW-1:0] RC_BLOCK =
        RW'(((ONE << RS_BLOCK_I) + 64'(BLOCK_WORDS) - ONE) / 64'(BLOCK_WORDS));
    localparam logic [RW-1:0] RC_LINES =
        RW'(((ONE << RS_LINES_I) + 64'(NUM_LINES) - ONE) / 64'(NUM_LINES));

    localparam logic [CW-1:0] CNT_MUL = CW'(2);
    localparam logic [CW-1:0] CNT_SUB = CW'(1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] rem_reg;
    logic [AW-1:0] quot_reg;
    logic [AW-1:0] dv_reg;
    logic [RW-1:0] rc_reg;
    logic [SW-1:0] rs_reg;

    logic [AW-1:0] sel_dv;
    logic          sel_p2;
    logic [SW-1:0] sel_sh;
    logic [AW-1:0] sel_mk;
    logic [RW-1:0] sel_rc;
    logic [SW-1:0] sel_rs;
    logic [PW-1:0] prod;
    logic [AW-1:0] recip_q;
    logic [AW-1:0] back_prod;

    always_comb
    begin
        unique case (req.op)
            dmwtc_pkg::DIV_MEM:
            begin
                sel_dv = DV_MEM;
                sel_p2 = P2_MEM;
                sel_sh = SH_MEM;
                sel_mk = MK_MEM;
                sel_rc = RC_MEM;
                sel_rs = RS_MEM;
            end
            dmwtc_pkg::DIV_CACHE:
            begin
                sel_dv = DV_CACHE;
                sel_p2 = P2_CACHE;
                sel_sh = SH_CACHE;
                sel_mk = MK_CACHE;
                sel_rc = RC_CACHE;
                sel_rs = RS_CACHE;
            end
            dmwtc_pkg::DIV_BLOCK:
            begin
                sel_dv = DV_BLOCK;
                sel_p2 = P2_BLOCK;
                sel_sh = SH_BLOCK;
                sel_mk = MK_BLOCK;
                sel_rc = RC_BLOCK;
                sel_rs = RS_BLOCK;
            end
            default:
            begin
                sel_dv = DV_LINES;
                sel_p2 = P2_LINES;
                sel_sh = SH_LINES;
                sel_mk = MK_LINES;
                sel_rc = RC_LINES;
                sel_rs = RS_LINES;
            end
        endcase
    end

    always_comb
    begin
        prod      = PW'(rem_reg) * PW'(rc_reg);
        recip_q   = AW'(prod >> rs_reg);
        back_prod = quot_reg * dv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (sel_p2)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_MUL;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_SUB)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dv_reg <= sel_dv;
            rc_reg <= sel_rc;
            rs_reg <= sel_rs;
            if (sel_p2)
            begin
                quot_reg <= req.dividend >> sel_sh;
                rem_reg  <= req.dividend & sel_mk;
            end
            else
            begin
                quot_reg <= '0;
                rem_reg  <= req.dividend;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_MUL)
            begin
                quot_reg <= recip_q;
            end
            else
            begin
                rem_reg <= rem_reg - back_prod;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// ----- src/direct_mapped_write_through_cache_core.sv -----
// Direct-mapped write-through write-allocate cache with its own main memory.
// After reset the core sweeps main memory and the tag store with busy high. An
// access is taken when start is high and busy is low and holds busy until its
// result strobes on done for one cycle; the receiver cannot hold the result off
// and must take it in that cycle. The address is split by one shared divider in
// five passes: shift and mask for a power-of-two divisor, reciprocal multiply and
// subtract otherwise. Then follow a tag read and a compare; a hit ends with a hit
// step, a miss first writes main memory if it is a write and then refills the
// whole line, one main-memory word per refill cycle.
`default_nettype none
module direct_mapped_write_through_cache_core #(
    parameter int MEM_WORDS   = 1024,
    parameter int CACHE_WORDS = 64,
    parameter int BLOCK_WORDS = 4
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire                action,
    input  wire         [9:0]  address,
    input  wire  signed [31:0] write_value,
    output logic               done,
    output logic               hit,
    output logic        [3:0]  line_index,
    output logic        [1:0]  word_offset,
    output logic        [3:0]  line_tag,
    output logic signed [31:0] word_value
);

    localparam int AW         = dmwtc_pkg::ADDR_W;
    localparam int WW         = dmwtc_pkg::WORD_W;
    localparam int RAW_LINES  = CACHE_WORDS / BLOCK_WORDS;
    localparam int NUM_LINES  = (RAW_LINES > 0) ? RAW_LINES : 1;
    localparam int DATA_WORDS = NUM_LINES * BLOCK_WORDS;
    localparam int LINE_AW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int DATA_AW    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int OFF_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int BLK_CW     = $clog2(BLOCK_WORDS + 1);
    localparam int SWEEP      = (MEM_WORDS > NUM_LINES) ? MEM_WORDS : NUM_LINES;
    localparam int SW_W       = $clog2(SWEEP);

    dmwtc_pkg::st_t      state_reg, state_next;
    dmwtc_pkg::div_req_t div_req;
    dmwtc_pkg::div_rsp_t div_rsp;
    dmwtc_pkg::tag_ent_t tag_mem [NUM_LINES];
    dmwtc_pkg::tag_ent_t tag_q_reg;

    logic [WW-1:0] main_mem [MEM_WORDS];
    logic [WW-1:0] data_mem [DATA_WORDS];
    logic [WW-1:0] mem_q_reg;
    logic [WW-1:0] data_q_reg;

    logic              iss_reg, iss_next;
    logic [SW_W-1:0]   sweep_reg, sweep_next;
    logic              action_reg, action_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [WW-1:0]     wval_reg, wval_next;
    logic [AW-1:0]     a_reg, a_next;
    logic [AW-1:0]     tag_reg, tag_next;
    logic [AW-1:0]     tmp_reg, tmp_next;
    logic [LINE_AW-1:0] line_reg, line_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [MEM_AW-1:0] ptr_reg, ptr_next;
    logic [DATA_AW-1:0] slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic [WW-1:0]     word_reg, word_next;
    logic [BLK_CW-1:0] issue_reg, issue_next;
    logic              rd_v_reg, rd_v_next;
    logic [BLK_CW-1:0] rd_idx_reg, rd_idx_next;

    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa;
    logic [WW-1:0]      mem_wd;
    logic [MEM_AW-1:0]  mem_ra;
    logic               tag_we;
    logic [LINE_AW-1:0] tag_wa;
    dmwtc_pkg::tag_ent_t tag_wd;
    logic               data_we;
    logic [DATA_AW-1:0] data_wa;
    logic [WW-1:0]      data_wd;
    logic [DATA_AW-1:0] data_ra;
    logic               accept;

    dmwtc_div #(
        .MEM_WORDS   (MEM_WORDS),
        .CACHE_WORDS (CACHE_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS),
        .NUM_LINES   (NUM_LINES)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept  = start && !busy;
    assign data_ra = DATA_AW'(slot_reg + DATA_AW'(off_reg));

    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        sweep_next  = sweep_reg;
        action_next = action_reg;
        addr_next   = addr_reg;
        wval_next   = wval_reg;
        a_next      = a_reg;
        tag_next    = tag_reg;
        tmp_next    = tmp_reg;
        line_next   = line_reg;
        off_next    = off_reg;
        ptr_next    = ptr_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        word_next   = word_reg;
        issue_next  = issue_reg;
        rd_v_next   = 1'b0;
        rd_idx_next = rd_idx_reg;

        div_req.start    = 1'b0;
        div_req.op       = dmwtc_pkg::DIV_MEM;
        div_req.dividend = addr_reg;

        mem_we  = 1'b0;
        mem_wa  = MEM_AW'(a_reg);
        mem_wd  = wval_reg;
        mem_ra  = ptr_reg;
        tag_we  = 1'b0;
        tag_wa  = line_reg;
        tag_wd  = '{valid: 1'b1, tag: tag_reg};
        data_we = 1'b0;
        data_wa = data_ra;
        data_wd = wval_reg;

        busy = (state_reg != dmwtc_pkg::ST_IDLE);
        done = 1'b0;

        unique case (state_reg)
            dmwtc_pkg::ST_INIT:
            begin
                mem_we = (32'(sweep_reg) < MEM_WORDS);
                mem_wa = MEM_AW'(sweep_reg);
                mem_wd = WW'(MEM_WORDS) - WW'(sweep_reg);
                tag_we = (32'(sweep_reg) < NUM_LINES);
                tag_wa = LINE_AW'(sweep_reg);
                tag_wd = '{valid: 1'b0, tag: '0};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SW_W'(SWEEP - 1))
                begin
                    state_next = dmwtc_pkg::ST_IDLE;
                end
            end
            dmwtc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    action_next = action;
                    addr_next   = address;
                    wval_next   = write_value;
                    state_next  = dmwtc_pkg::ST_DIV_MOD;
                end
            end
            dmwtc_pkg::ST_DIV_MOD,
            dmwtc_pkg::ST_DIV_TAG,
            dmwtc_pkg::ST_DIV_LRAW,
            dmwtc_pkg::ST_DIV_LINE,
            dmwtc_pkg::ST_DIV_OFF:
            begin
                div_req.start = !iss_reg;
                iss_next      = 1'b1;
                unique case (state_reg)
                    dmwtc_pkg::ST_DIV_MOD:
                    begin
                        div_req.op       = dmwtc_pkg::DIV_MEM;
                        div_req.dividend = addr_reg;
                    end
                    dmwtc_pkg::ST_DIV_TAG:
                    begin
                        div_req.op       = dmwtc_pkg::DIV_CACHE;
                        div_req.dividend = a_reg;
                    end
                    dmwtc_pkg::ST_DIV_LRAW:
                    begin
                        div_req.op       = dmwtc_pkg::DIV_BLOCK;
                        div_req.dividend = tmp_reg;
                    end
                    dmwtc_pkg::ST_DIV_LINE:
                    begin
                        div_req.op       = dmwtc_pkg::DIV_LINES;
                        div_req.dividend = tmp_reg;
                    end
                    default:
                    begin
                        div_req.op       = dmwtc_pkg::DIV_BLOCK;
                        div_req.dividend = a_reg;
                    end
                endcase
                if (iss_reg && div_rsp.done)
                begin
                    iss_next = 1'b0;
                    unique case (state_reg)
                        dmwtc_pkg::ST_DIV_MOD:
                        begin
                            a_next     = div_rsp.rem;
                            state_next = dmwtc_pkg::ST_DIV_TAG;
                        end
                        dmwtc_pkg::ST_DIV_TAG:
                        begin
                            tag_next   = div_rsp.quot;
                            tmp_next   = div_rsp.rem;
                            state_next = dmwtc_pkg::ST_DIV_LRAW;
                        end
                        dmwtc_pkg::ST_DIV_LRAW:
                        begin
                            tmp_next   = div_rsp.quot;
                            state_next = dmwtc_pkg::ST_DIV_LINE;
                        end
                        dmwtc_pkg::ST_DIV_LINE:
                        begin
                            line_next  = LINE_AW'(div_rsp.rem);
                            state_next = dmwtc_pkg::ST_DIV_OFF;
                        end
                        default:
                        begin
                            off_next   = OFF_W'(div_rsp.rem);
                            ptr_next   = MEM_AW'(AW'(a_reg - div_rsp.rem));
                            state_next = dmwtc_pkg::ST_TAG_RD;
                        end
                    endcase
                end
            end
            dmwtc_pkg::ST_TAG_RD:
            begin
                slot_next  = DATA_AW'(32'(line_reg) * BLOCK_WORDS);
                state_next = dmwtc_pkg::ST_CHECK;
            end
            dmwtc_pkg::ST_CHECK:
            begin
                hit_next   = tag_q_reg.valid && (tag_q_reg.tag == tag_reg);
                issue_next = '0;
                if (tag_q_reg.valid && (tag_q_reg.tag == tag_reg))
                begin
                    state_next = dmwtc_pkg::ST_HIT_RD;
                end
                else
                begin
                    tag_we     = 1'b1;
                    state_next = action_reg ? dmwtc_pkg::ST_MEM_WR : dmwtc_pkg::ST_FILL;
                end
            end
            dmwtc_pkg::ST_MEM_WR:
            begin
                mem_we     = 1'b1;
                state_next = dmwtc_pkg::ST_FILL;
            end
            dmwtc_pkg::ST_FILL:
            begin
                if (issue_reg != BLK_CW'(BLOCK_WORDS))
                begin
                    rd_v_next   = 1'b1;
                    rd_idx_next = issue_reg;
                    issue_next  = issue_reg + 1'b1;
                    ptr_next    = (ptr_reg == MEM_AW'(MEM_WORDS - 1)) ? '0 : ptr_reg + 1'b1;
                end
                if (rd_v_reg)
                begin
                    data_we = 1'b1;
                    data_wa = DATA_AW'(slot_reg + DATA_AW'(rd_idx_reg));
                    data_wd = mem_q_reg;
                    if (rd_idx_reg == BLK_CW'(off_reg))
                    begin
                        word_next = mem_q_reg;
                    end
                    if (rd_idx_reg == BLK_CW'(BLOCK_WORDS - 1))
                    begin
                        state_next = dmwtc_pkg::ST_DONE;
                    end
                end
            end
            dmwtc_pkg::ST_HIT_RD:
            begin
                if (action_reg)
                begin
                    data_we   = 1'b1;
                    mem_we    = 1'b1;
                    word_next = wval_reg;
                end
                state_next = dmwtc_pkg::ST_DONE;
            end
            dmwtc_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = dmwtc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dmwtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmwtc_pkg::ST_INIT;
            iss_reg   <= 1'b0;
            sweep_reg <= '0;
            issue_reg <= '0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            sweep_reg <= sweep_next;
            issue_reg <= issue_next;
            rd_v_reg  <= rd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        addr_reg   <= addr_next;
        wval_reg   <= wval_next;
        a_reg      <= a_next;
        tag_reg    <= tag_next;
        tmp_reg    <= tmp_next;
        line_reg   <= line_next;
        off_reg    <= off_next;
        ptr_reg    <= ptr_next;
        slot_reg   <= slot_next;
        hit_reg    <= hit_next;
        word_reg   <= word_next;
        rd_idx_reg <= rd_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= main_mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        tag_q_reg <= tag_mem[line_reg];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        data_q_reg <= data_mem[data_ra];
    end

    always_comb
    begin
        hit         = hit_reg;
        line_index  = dmwtc_pkg::LINE_OUT_W'(line_reg);
        word_offset = dmwtc_pkg::OFF_OUT_W'(off_reg);
        line_tag    = tag_reg[dmwtc_pkg::TAG_OUT_W-1:0];
        word_value  = (hit_reg && !action_reg) ? data_q_reg : word_reg;
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside an access");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start an access");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("core did not return to idle after its result");

    a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> !hit_reg)
        else $error("refill running on a hit");

endmodule
`default_nettype wire

// ----- sim/tb_direct_mapped_write_through_cache_core.sv -----
// Self-checking testbench for the direct-mapped write-through cache core.
`default_nettype none
module tb_direct_mapped_write_through_cache_core;

    localparam int MEM_DEPTH   = 1024;
    localparam int CACHE_DEPTH = 64;
    localparam int BLOCK_LEN   = 4;
    localparam int LINE_COUNT  = CACHE_DEPTH / BLOCK_LEN;
    localparam int AW          = dmwtc_pkg::ADDR_W;
    localparam int WW          = dmwtc_pkg::WORD_W;
    localparam bit ACT_READ    = 1'b0;
    localparam bit ACT_WRITE   = 1'b1;
    localparam int RANDOM_WORDS = 540;
    localparam int HOT_SET     = 6;

    typedef struct packed {
        logic          hit;
        logic [3:0]    line;
        logic [1:0]    off;
        logic [3:0]    tag;
        logic [WW-1:0] value;
    } cache_word_t;

    class cache_tracker;
        logic [WW-1:0] mem_words [MEM_DEPTH];
        bit            line_ok [LINE_COUNT];
        logic [AW-1:0] line_tag_q [LINE_COUNT];
        logic [WW-1:0] line_words [LINE_COUNT*BLOCK_LEN];
        cache_word_t   expected_words [$];
        int            mismatches;
        int            strays;
        int            reads;
        int            writes;
        int            hits;
        int            misses;

        function new();
            for (int i = 0; i < MEM_DEPTH; i++)
                mem_words[i] = MEM_DEPTH - i;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                line_ok[i]    = 1'b0;
                line_tag_q[i] = '0;
            end
            for (int i = 0; i < LINE_COUNT*BLOCK_LEN; i++)
                line_words[i] = '0;
            mismatches = 0;
            strays     = 0;
            reads      = 0;
            writes     = 0;
            hits       = 0;
            misses     = 0;
        endfunction

        function logic [WW-1:0] stored(logic [AW-1:0] addr);
            return mem_words[addr % MEM_DEPTH];
        endfunction

        function cache_word_t predict_access(bit act, logic [AW-1:0] addr,
                                             logic [WW-1:0] wval);
            int unsigned a;
            int unsigned tg;
            int unsigned ln;
            int unsigned off;
            int unsigned slot;
            int unsigned base;
            bit          h;
            cache_word_t r;
            a    = addr % MEM_DEPTH;
            tg   = a / CACHE_DEPTH;
            ln   = ((a % CACHE_DEPTH) / BLOCK_LEN) % LINE_COUNT;
            off  = a % BLOCK_LEN;
            slot = ln * BLOCK_LEN;
            h    = line_ok[ln] && (line_tag_q[ln] == tg);
            if (!h)
            begin
                base = (a / BLOCK_LEN) * BLOCK_LEN;
                if (act == ACT_WRITE)
                    mem_words[a] = wval;
                line_ok[ln]    = 1'b1;
                line_tag_q[ln] = AW'(tg);
                for (int i = 0; i < BLOCK_LEN; i++)
                    line_words[slot + i] = mem_words[(base + i) % MEM_DEPTH];
            end
            else if (act == ACT_WRITE)
            begin
                line_words[slot + off] = wval;
                mem_words[a]           = wval;
            end
            r.hit   = h;
            r.line  = ln[3:0];
            r.off   = off[1:0];
            r.tag   = line_tag_q[ln][3:0];
            r.value = line_words[slot + off];
            return r;
        endfunction

        function void note_access(bit act, logic [AW-1:0] addr, logic [WW-1:0] wval);
            expected_words.push_back(predict_access(act, addr, wval));
            if (act == ACT_WRITE)
                writes++;
            else
                reads++;
        endfunction

        function void check_word(cache_word_t got);
            cache_word_t want;
            if (got.hit)
                hits++;
            else
                misses++;
            if (expected_words.size() == 0)
            begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("%0t: unexpected word hit=%0b line=%0d off=%0d tag=%0d value=%h",
                             $realtime, got.hit, got.line, got.off, got.tag, got.value);
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches + strays <= 10)
                begin
                    $display("%0t: mismatch exp hit=%0b line=%0d off=%0d tag=%0d value=%h",
                             $realtime, want.hit, want.line, want.off, want.tag, want.value);
                    $display("%0t:          got hit=%0b line=%0d off=%0d tag=%0d value=%h",
                             $realtime, got.hit, got.line, got.off, got.tag, got.value);
                end
            end
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 action      = ACT_READ;
    logic        [AW-1:0] address     = '0;
    logic signed [WW-1:0] write_value = '0;
    logic                 busy;
    logic                 done;
    logic                 hit;
    logic        [3:0]    line_index;
    logic        [1:0]    word_offset;
    logic        [3:0]    line_tag;
    logic signed [WW-1:0] word_value;

    cache_tracker tracker;
    int           burst_left = 0;

    direct_mapped_write_through_cache_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .address     (address),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .line_index  (line_index),
        .word_offset (word_offset),
        .line_tag    (line_tag),
        .word_value  (word_value)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin : result_monitor
        cache_word_t seen;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            seen.hit   = hit;
            seen.line  = line_index;
            seen.off   = word_offset;
            seen.tag   = line_tag;
            seen.value = word_value;
            tracker.check_word(seen);
        end
    end

    task automatic push_access(bit act, logic [AW-1:0] addr, logic [WW-1:0] wval);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start       <= 1'b1;
        action      <= act;
        address     <= addr;
        write_value <= wval;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_access(act, addr, wval);
    endtask

    task automatic run_directed();
        push_access(ACT_READ,  10'd0,    32'h0);
        push_access(ACT_READ,  10'd3,    32'hFFFF_FFFF);
        push_access(ACT_WRITE, 10'd2,    32'h7FFF_FFFF);
        push_access(ACT_READ,  10'd2,    32'h0);
        push_access(ACT_WRITE, 10'd1023, 32'h8000_0000);
        push_access(ACT_READ,  10'd1020, 32'h0);
        push_access(ACT_READ,  10'd960,  32'h0);
        push_access(ACT_READ,  10'd2,    32'h0);
        push_access(ACT_WRITE, 10'd2,    32'h7FFF_FFFF);
        push_access(ACT_WRITE, 10'd5,    32'h0);
        push_access(ACT_WRITE, 10'd5,    32'hFFFF_FFFF);
        push_access(ACT_READ,  10'd1023, 32'h0);
        push_access(ACT_WRITE, 10'h2AA,  32'hAAAA_AAAA);
        push_access(ACT_READ,  10'h155,  32'h5555_5555);
        push_access(ACT_WRITE, 10'h155,  32'h5555_5555);
        push_access(ACT_READ,  10'h2AA,  32'h0);
        push_access(ACT_WRITE, 10'd63,   32'h0000_0001);
        push_access(ACT_READ,  10'd1,    32'h0);
    endtask

    task automatic run_random();
        logic [AW-1:0] hot [HOT_SET];
        logic [AW-1:0] addr;
        logic [AW-1:0] last_addr;
        logic [WW-1:0] wval;
        bit            act;
        int            pick;
        last_addr = '0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
                for (int k = 0; k < HOT_SET; k++)
                    hot[k] = AW'($urandom_range(0, MEM_DEPTH - 1));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                addr = hot[$urandom_range(0, HOT_SET - 1)] ^ AW'($urandom_range(0, 3));
            else if (pick < 75)
                addr = {4'($urandom_range(0, 15)), last_addr[5:2], 2'($urandom_range(0, 3))};
            else
                addr = AW'($urandom_range(0, MEM_DEPTH - 1));
            act  = 1'($urandom_range(0, 1));
            wval = $urandom();
            if ($urandom_range(0, 19) == 0)
                wval = tracker.stored(addr);
            push_access(act, addr, wval);
            last_addr = addr;
        end
    endtask

    initial
    begin
        int fails;
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        start <= 1'b0;
        while (tracker.expected_words.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        fails = tracker.mismatches + tracker.strays + tracker.expected_words.size();
        $display("covered %0d reads and %0d writes, %0d hits and %0d misses observed",
                 tracker.reads, tracker.writes, tracker.hits, tracker.misses);
        $display("mismatches %0d, unexpected words %0d, missing words %0d",
                 tracker.mismatches, tracker.strays, tracker.expected_words.size());
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("timeout waiting for the core");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
